>>> rtl/htops_pkg.sv
// ---------------------------------------------------------------------------
// Half-time smoother package
// Shared widths, constants and the fractional-power root table used by the
// half-time one-pole smoother.
// ---------------------------------------------------------------------------
package htops_pkg;

  // Field and arithmetic widths.
  localparam int SAMPLE_BITS    = 24;
  localparam int COEFF_BITS     = 24;
  localparam int HALF_TIME_BITS = 24;
  localparam int RATE_BITS      = 18;
  localparam int EXP_FRAC       = 24;
  localparam int ACC_FRAC       = 32;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + HALF_TIME_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  // Exponent division: E_q = 1e6 * 2^EXP_FRAC / (rate * half_time).
  localparam int DIVISOR_BITS = RATE_BITS + HALF_TIME_BITS;
  localparam int QUOT_BITS    = 20 + EXP_FRAC;
  localparam int EXP_INT_BITS = QUOT_BITS - EXP_FRAC;
  localparam logic [QUOT_BITS-1:0] EXP_DIVIDEND =
    QUOT_BITS'(64'd1000000 << EXP_FRAC);
  localparam int DIV_CNT_BITS = $clog2(QUOT_BITS);

  // Largest whole-number exponent applied as a shift; a larger one gives a zero coefficient.
  localparam int MAX_SHIFT   = ACC_FRAC;
  localparam int SHIFT_BITS  = $clog2(MAX_SHIFT + 1);
  localparam int STEP_BITS   = $clog2(EXP_FRAC + 1);

  localparam logic [COEFF_BITS-1:0] COEFF_MAX = '1;

  typedef logic [EXP_FRAC:1][ACC_FRAC-1:0] root_rom_t;

  // Floor square root of a 64-bit value, two bits per step.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Entry k holds 2^(-2^-k) in Q0.32, each one the root of the one before.
  function automatic root_rom_t build_root_rom();
    root_rom_t   rom;
    logic [63:0] r;
    r      = isqrt64(64'd1 << 63);
    rom[1] = r[ACC_FRAC-1:0];
    for (int k = 2; k <= EXP_FRAC; k++) begin
      r      = isqrt64({r[ACC_FRAC-1:0], 32'd0});
      rom[k] = r[ACC_FRAC-1:0];
    end
    return rom;
  endfunction

  localparam root_rom_t ROOT_ROM = build_root_rom();

endpackage

>>> rtl/half_time_one_pole_smoother_core.sv
// ---------------------------------------------------------------------------
// Half-time one-pole smoother core
// One-pole lowpass y = (1-a)*x + a*y_prev whose coefficient a is derived
// from a half-time in microseconds and the configured sample rate.
// ---------------------------------------------------------------------------
// Each item carries one Q1.23 sample and a half-time. When the half-time
// matches the one used last (and the sample rate has not been rewritten),
// the cached coefficient is reused and an item goes straight from accept
// to the difference, scaled-step and result states. Otherwise the
// coefficient is rebuilt first: the rate times half-time product, the
// bit-serial divider that forms the exponent, the shared multiplier
// stepping through the fractional power table and the final shift. A zero
// half-time or zero rate skips the rebuild and gives pass-through. The
// input is not ready while an item is in flight; a finished result waits
// in the output register without blocking the next accept, though the
// following item cannot finish until it is taken.
// The first sample after reset passes through unchanged.
module half_time_one_pole_smoother_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Sample-rate register write.
  input  logic                                 cfg_we_i,
  input  logic [htops_pkg::RATE_BITS-1:0]      cfg_wdata_i,
  // Input items.
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // sample_in [23:0], half_time_us [47:24]
  input  logic [htops_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // Result items.
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // sample_out [23:0]
  output logic [htops_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata
);
  import htops_pkg::*;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_PROD  = 8'b0000_0010,
    ST_DIV   = 8'b0000_0100,
    ST_POW   = 8'b0000_1000,
    ST_SHIFT = 8'b0001_0000,
    ST_DIFF  = 8'b0010_0000,
    ST_FMUL  = 8'b0100_0000,
    ST_DONE  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  logic [RATE_BITS-1:0]      rate_q;
  logic                      cache_valid_q;
  logic [HALF_TIME_BITS-1:0] cached_ht_q;
  logic                      first_q;
  logic [SAMPLE_BITS-1:0]    filt_q;
  logic [COEFF_BITS-1:0]     coeff_q;
  logic [SAMPLE_BITS-1:0]    x_q;
  logic [HALF_TIME_BITS-1:0] ht_q;
  logic [DIVISOR_BITS-1:0]   divisor_q;
  logic [DIVISOR_BITS-1:0]   rem_q;
  logic [QUOT_BITS-1:0]      quot_q;
  logic [DIV_CNT_BITS-1:0]   div_cnt_q;
  logic [ACC_FRAC:0]         acc_q;
  logic [STEP_BITS-1:0]      step_q;
  logic [SAMPLE_BITS-1:0]    mag_q;
  logic                      neg_q;
  logic [SAMPLE_BITS-1:0]    quo_q;
  logic                      out_valid_q;
  logic [SAMPLE_BITS-1:0]    out_data_q;

  logic                      s_accept;
  logic [SAMPLE_BITS-1:0]    in_x;
  logic [HALF_TIME_BITS-1:0] in_ht;
  logic                      need_coeff;
  logic [DIVISOR_BITS-1:0]   divisor_d;
  logic [DIVISOR_BITS:0]     rem_shift;
  logic                      div_ge;
  logic [DIVISOR_BITS:0]     rem_sub;
  logic [2*ACC_FRAC:0]       pow_prod;
  logic [EXP_INT_BITS-1:0]   exp_int;
  logic [ACC_FRAC:0]         acc_shifted;
  logic [COEFF_BITS:0]       coeff_hi;
  logic [COEFF_BITS-1:0]     coeff_new;
  logic [SAMPLE_BITS-1:0]    prev;
  logic [SAMPLE_BITS:0]      diff;
  logic [SAMPLE_BITS:0]      diff_abs;
  logic [SAMPLE_BITS+COEFF_BITS-1:0] filt_prod;
  logic [SAMPLE_BITS:0]      y_ext;
  logic                      out_free;

  // Handshake and input field split.
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_x          = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_ht         = s_axis_tdata[SAMPLE_BITS +: HALF_TIME_BITS];
  assign need_coeff    = !cache_valid_q || (in_ht != cached_ht_q);
  assign out_free      = !out_valid_q || m_axis_tready;

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_DATA_BITS'(out_data_q);

  // Divisor product and one restoring-division step.
  assign divisor_d = DIVISOR_BITS'(rate_q) * DIVISOR_BITS'(ht_q);
  assign rem_shift = {rem_q, EXP_DIVIDEND[div_cnt_q]};
  assign div_ge    = rem_shift >= {1'b0, divisor_q};
  assign rem_sub   = rem_shift - {1'b0, divisor_q};

  // Shared multiplier for the fractional power steps.
  assign pow_prod = acc_q * ROOT_ROM[step_q];

  // Whole-number part of the exponent as a right shift, then clamp.
  assign exp_int     = quot_q[QUOT_BITS-1:EXP_FRAC];
  assign acc_shifted = acc_q >> exp_int[SHIFT_BITS-1:0];
  assign coeff_hi    = acc_shifted[ACC_FRAC:ACC_FRAC-COEFF_BITS];
  always_comb begin
    if (exp_int > EXP_INT_BITS'(MAX_SHIFT)) begin
      coeff_new = '0;
    end else if (coeff_hi[COEFF_BITS]) begin
      coeff_new = COEFF_MAX;
    end else begin
      coeff_new = coeff_hi[COEFF_BITS-1:0];
    end
  end

  // Filter datapath: difference, its magnitude, scaled step and result.
  // The result always lies between the input and the previous output.
  assign prev      = first_q ? x_q : filt_q;
  assign diff      = {prev[SAMPLE_BITS-1], prev} - {x_q[SAMPLE_BITS-1], x_q};
  assign diff_abs  = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
  assign filt_prod = SAMPLE_BITS'(mag_q) * COEFF_BITS'(coeff_q);
  assign y_ext     = neg_q ? ({x_q[SAMPLE_BITS-1], x_q} - {1'b0, quo_q})
                           : ({x_q[SAMPLE_BITS-1], x_q} + {1'b0, quo_q});

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_accept) begin
          state_d = need_coeff ? ST_PROD : ST_DIFF;
        end
      end
      ST_PROD: begin
        state_d = (divisor_d == '0) ? ST_DIFF : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_q == '0) begin
          state_d = ST_POW;
        end
      end
      ST_POW: begin
        if (step_q == STEP_BITS'(EXP_FRAC)) begin
          state_d = ST_SHIFT;
        end
      end
      ST_SHIFT: state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_FMUL;
      ST_FMUL:  state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration, cache and filter state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q        <= RATE_BITS'(48000);
      cache_valid_q <= 1'b0;
      cached_ht_q   <= '0;
      first_q       <= 1'b1;
      filt_q        <= '0;
      coeff_q       <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q        <= cfg_wdata_i;
        cache_valid_q <= 1'b0;
      end else if (s_accept && need_coeff) begin
        cached_ht_q   <= in_ht;
        cache_valid_q <= 1'b1;
      end
      if (state_q == ST_PROD && divisor_d == '0) begin
        coeff_q <= '0;
      end
      if (state_q == ST_SHIFT) begin
        coeff_q <= coeff_new;
      end
      if (state_q == ST_DIFF) begin
        first_q <= 1'b0;
      end
      if (state_q == ST_DONE && out_free) begin
        filt_q      <= y_ext[SAMPLE_BITS-1:0];
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Working registers of the shared unit.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      x_q  <= in_x;
      ht_q <= in_ht;
    end
    case (state_q)
      ST_PROD: begin
        divisor_q <= divisor_d;
        rem_q     <= '0;
        quot_q    <= '0;
        div_cnt_q <= DIV_CNT_BITS'(QUOT_BITS - 1);
        acc_q     <= (ACC_FRAC + 1)'(1) << ACC_FRAC;
        step_q    <= STEP_BITS'(1);
      end
      ST_DIV: begin
        rem_q     <= div_ge ? rem_sub[DIVISOR_BITS-1:0] : rem_shift[DIVISOR_BITS-1:0];
        quot_q    <= {quot_q[QUOT_BITS-2:0], div_ge};
        div_cnt_q <= div_cnt_q - 1'b1;
      end
      ST_POW: begin
        // Top fraction bit weighs 2^-step; multiply in its root when set.
        if (quot_q[EXP_FRAC-1]) begin
          acc_q <= pow_prod[2*ACC_FRAC:ACC_FRAC];
        end
        quot_q[EXP_FRAC-1:0] <= {quot_q[EXP_FRAC-2:0], 1'b0};
        step_q <= step_q + 1'b1;
      end
      ST_DIFF: begin
        neg_q <= diff[SAMPLE_BITS];
        mag_q <= diff_abs[SAMPLE_BITS-1:0];
      end
      ST_FMUL: begin
        quo_q <= filt_prod[COEFF_BITS +: SAMPLE_BITS];
      end
      default: ;
    endcase
    if (state_q == ST_DONE && out_free) begin
      out_data_q <= y_ext[SAMPLE_BITS-1:0];
    end
  end

endmodule

>>> rtl/htops_checker.sv
// ---------------------------------------------------------------------------
// Half-time smoother port checker
// Watches the top-level ports of the smoother over time and binds to it.
// ---------------------------------------------------------------------------
module htops_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                s_axis_tvalid,
  input logic                                s_axis_tready,
  input logic [htops_pkg::OUT_DATA_BITS-1:0] m_axis_tdata,
  input logic                                m_axis_tvalid,
  input logic                                m_axis_tready
);
  import htops_pkg::*;

  logic s_accept;
  assign s_accept = s_axis_tvalid && s_axis_tready;

  // A result that is not taken stays offered with the same data.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result item dropped or changed while stalled");

  // The block works on one item at a time.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept |=> !s_axis_tready)
    else $error("input ready right after an accepted item");

  // A new result only appears at the end of work, when the input was busy.
  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result item appeared without work in progress");

endmodule

bind half_time_one_pole_smoother_core htops_checker u_htops_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
